// ===== hdl/strict_priority_event_queue_unit_macros.svh =====
// Assertion macros used by the checker file speq_checker.sv.
`ifndef STRICT_PRIORITY_EVENT_QUEUE_UNIT_MACROS_SVH
`define STRICT_PRIORITY_EVENT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPEQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SPEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/speq_pkg.sv =====
`timescale 1ns / 1ps
package speq_pkg;

   localparam int NUM_CLASSES = 3;
   localparam int RING_DEPTH  = 16;

   localparam int CLS_W   = $clog2(NUM_CLASSES);
   localparam int PTR_W   = $clog2(RING_DEPTH);
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_CLASSES * RING_DEPTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);

   localparam int CMD_W     = 2;
   localparam int PRIO_W    = 8;
   localparam int TTL_W     = 16;
   localparam int PAYLOAD_W = 32;
   localparam int TIME_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int OCLS_W    = 2;
   localparam int RUN_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_RUN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_RUN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_RUN   = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_EXPIRED = 2'd3
   } status_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [TTL_W-1:0]     ttl;
      logic [TIME_W-1:0]    stamp;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [PTR_W-1:0] ptr);
      return ADDR_W'(ADDR_W'(cls) * ADDR_W'(RING_DEPTH)) + ADDR_W'(ptr);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
   endfunction

endpackage

// ===== hdl/speq_entry_mem.sv =====
`timescale 1ns / 1ps
module speq_entry_mem (
   input  logic                clock,
   input  speq_pkg::mem_wr_type wr,
   input  speq_pkg::mem_rd_type rd,
   output speq_pkg::entry_type  rd_data
);
   import speq_pkg::*;

   entry_type mem_ff [MEM_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/strict_priority_event_queue_unit.sv =====
`timescale 1ns / 1ps
// Channel     | Handshake             | Payload
// ------------+-----------------------+------------------------------------------------
// request     | start / busy          | req_command, req_priority_req, req_ttl,
//             |                       | req_payload, req_now_ms
// response    | rsp_valid (strobe)    | rsp_status, rsp_out_payload, rsp_out_class,
//             |                       | rsp_run_priority, rsp_all_empty
// config      | csr_valid / csr_ready | csr_index, csr_wdata
//
// Push, clear, unused and pop-when-empty commands strobe their response in the next cycle.
// A pop of a nonempty ring goes through ST_POP because the entry memory read is registered.
// Busy is high only while a pop is in ST_POP; start is ignored while busy.
// Reset is synchronous; the entry memory needs no clearing pass.
// The response has no back-pressure; csr_ready is always high.
module strict_priority_event_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [speq_pkg::CMD_W-1:0]          req_command,
   input  logic [speq_pkg::PRIO_W-1:0]         req_priority_req,
   input  logic [speq_pkg::TTL_W-1:0]          req_ttl,
   input  logic [speq_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [speq_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   output logic [speq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [speq_pkg::PAYLOAD_W-1:0]      rsp_out_payload,
   output logic [speq_pkg::OCLS_W-1:0]         rsp_out_class,
   output logic signed [speq_pkg::RUN_W-1:0]   rsp_run_priority,
   output logic                                rsp_all_empty,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [speq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [speq_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import speq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         rd_ptr_ff [NUM_CLASSES];
   logic [PTR_W-1:0]         rd_ptr_in [NUM_CLASSES];
   logic [PTR_W-1:0]         wr_ptr_ff [NUM_CLASSES];
   logic [PTR_W-1:0]         wr_ptr_in [NUM_CLASSES];
   logic [CNT_W-1:0]         cnt_ff [NUM_CLASSES];
   logic [CNT_W-1:0]         cnt_in [NUM_CLASSES];
   logic signed [RUN_W-1:0]  low_run_ff, low_run_in;
   logic signed [RUN_W-1:0]  normal_run_ff, normal_run_in;
   logic signed [RUN_W-1:0]  high_run_ff, high_run_in;
   logic [CLS_W-1:0]         pop_cls_ff, pop_cls_in;
   logic [TIME_W-1:0]        pop_now_ff, pop_now_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_W-1:0]     rsp_payload_ff, rsp_payload_in;
   logic [OCLS_W-1:0]        rsp_class_ff, rsp_class_in;
   logic signed [RUN_W-1:0]  rsp_run_ff, rsp_run_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   logic                     accept;
   logic [CLS_W-1:0]         push_cls;
   logic                     push_full;
   logic [CLS_W-1:0]         top_cls;
   logic                     top_found;
   logic                     expired;
   logic [TIME_W-1:0]        deadline;
   logic signed [RUN_W-1:0]  cls_run;
   mem_wr_type               mem_wr;
   mem_rd_type               mem_rd;
   entry_type                mem_rd_data;

   speq_entry_mem u_entry_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign push_cls  = (req_priority_req >= PRIO_W'(NUM_CLASSES)) ?
                      CLS_W'(NUM_CLASSES - 1) : CLS_W'(req_priority_req);
   assign push_full = (cnt_ff[push_cls] == CNT_W'(RING_DEPTH));

   always_comb begin
      top_cls   = '0;
      top_found = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (cnt_ff[c] != '0) begin
            top_cls   = CLS_W'(c);
            top_found = 1'b1;
         end
      end
   end

   assign deadline = mem_rd_data.stamp + TIME_W'(mem_rd_data.ttl);
   assign expired  = (mem_rd_data.ttl != '0) && (pop_now_ff > deadline);

   always_comb begin
      if (pop_cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
         cls_run = high_run_ff;
      end else if (pop_cls_ff == '0) begin
         cls_run = low_run_ff;
      end else begin
         cls_run = normal_run_ff;
      end
   end

   always_comb begin
      mem_wr.en         = 1'b0;
      mem_wr.addr       = slot_addr(push_cls, wr_ptr_ff[push_cls]);
      mem_wr.data.payload = req_payload;
      mem_wr.data.ttl   = req_ttl;
      mem_wr.data.stamp = req_now_ms;
      mem_rd.en         = 1'b0;
      mem_rd.addr       = slot_addr(top_cls, rd_ptr_ff[top_cls]);

      state_in       = state_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      cnt_in         = cnt_ff;
      pop_cls_in     = pop_cls_ff;
      pop_now_in     = pop_now_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_empty_in   = rsp_empty_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_DONE;
               rsp_payload_in = '0;
               rsp_class_in   = '0;
               rsp_run_in     = '0;
               case (command_type'(req_command))
                  CMD_PUSH: begin
                     rsp_class_in = OCLS_W'(push_cls);
                     if (push_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_wr.en           = 1'b1;
                        wr_ptr_in[push_cls] = ptr_next(wr_ptr_ff[push_cls]);
                        cnt_in[push_cls]    = CNT_W'(cnt_ff[push_cls] + 1'b1);
                     end
                  end
                  CMD_POP: begin
                     if (top_found) begin
                        mem_rd.en          = 1'b1;
                        rd_ptr_in[top_cls] = ptr_next(rd_ptr_ff[top_cls]);
                        cnt_in[top_cls]    = CNT_W'(cnt_ff[top_cls] - 1'b1);
                        pop_cls_in         = top_cls;
                        pop_now_in         = req_now_ms;
                        rsp_valid_in       = 1'b0;
                        state_in           = ST_POP;
                     end else begin
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  CMD_CLEAR: begin
                     for (int c = 0; c < NUM_CLASSES; c++) begin
                        rd_ptr_in[c] = '0;
                        wr_ptr_in[c] = '0;
                        cnt_in[c]    = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_empty_in = 1'b1;
               for (int c = 0; c < NUM_CLASSES; c++) begin
                  if (cnt_in[c] != '0) begin
                     rsp_empty_in = 1'b0;
                  end
               end
            end
         end
         ST_POP: begin
            rsp_valid_in = 1'b1;
            rsp_class_in = OCLS_W'(pop_cls_ff);
            state_in     = ST_IDLE;
            if (expired) begin
               rsp_status_in = STAT_EXPIRED;
            end else begin
               rsp_status_in  = STAT_DONE;
               rsp_payload_in = mem_rd_data.payload;
               rsp_run_in     = cls_run;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      low_run_in    = low_run_ff;
      normal_run_in = normal_run_ff;
      high_run_in   = high_run_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOW_RUN:    low_run_in    = csr_wdata;
            CSR_NORMAL_RUN: normal_run_in = csr_wdata;
            CSR_HIGH_RUN:   high_run_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         low_run_ff    <= '0;
         normal_run_ff <= '0;
         high_run_ff   <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= '0;
            wr_ptr_ff[c] <= '0;
            cnt_ff[c]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         low_run_ff    <= low_run_in;
         normal_run_ff <= normal_run_in;
         high_run_ff   <= high_run_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         cnt_ff        <= cnt_in;
      end
      pop_cls_ff     <= pop_cls_in;
      pop_now_ff     <= pop_now_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_run_ff     <= rsp_run_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_out_class    = rsp_class_ff;
   assign rsp_run_priority = rsp_run_ff;
   assign rsp_all_empty    = rsp_empty_ff;

endmodule

// ===== hdl/speq_checker.sv =====
`timescale 1ns / 1ps
`include "strict_priority_event_queue_unit_macros.svh"
module speq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [speq_pkg::STATUS_W-1:0]     rsp_status,
   input logic [speq_pkg::PAYLOAD_W-1:0]    rsp_out_payload,
   input logic signed [speq_pkg::RUN_W-1:0] rsp_run_priority,
   input logic                              rsp_all_empty
);
   import speq_pkg::*;

   `SPEQ_ASSERT_NEXT(a_transfer_answered, clock, reset, start && !busy, rsp_valid || busy, "accepted transfer produced neither a response nor a pending pop")
   `SPEQ_ASSERT_NEXT(a_pop_one_extra_cycle, clock, reset, busy, !busy && rsp_valid, "pop did not finish after one busy cycle")
   `SPEQ_ASSERT_SAME(a_no_strobe_while_busy, clock, reset, busy, !rsp_valid, "response strobe while a pop is in flight")
   `SPEQ_ASSERT_SAME(a_empty_pop_reports_empty, clock, reset, rsp_valid && (rsp_status == STAT_EMPTY), rsp_all_empty, "empty pop without all rings empty")
   `SPEQ_ASSERT_SAME(a_expired_zero_fields, clock, reset, rsp_valid && (rsp_status == STAT_EXPIRED), (rsp_out_payload == '0) && (rsp_run_priority == '0), "expired entry delivered data")

endmodule

bind strict_priority_event_queue_unit speq_checker u_speq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_out_payload  (rsp_out_payload),
   .rsp_run_priority (rsp_run_priority),
   .rsp_all_empty    (rsp_all_empty)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import speq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      status_type               status;
      logic [PAYLOAD_W-1:0]     payload;
      logic [OCLS_W-1:0]        cls;
      logic signed [RUN_W-1:0]  run;
      logic                     all_empty;
   } queue_result_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [CMD_W-1:0]            req_command;
   logic [PRIO_W-1:0]           req_priority_req;
   logic [TTL_W-1:0]            req_ttl;
   logic [PAYLOAD_W-1:0]        req_payload;
   logic [TIME_W-1:0]           req_now_ms;
   logic                        rsp_valid;
   logic [STATUS_W-1:0]         rsp_status;
   logic [PAYLOAD_W-1:0]        rsp_out_payload;
   logic [OCLS_W-1:0]           rsp_out_class;
   logic signed [RUN_W-1:0]     rsp_run_priority;
   logic                        rsp_all_empty;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DAT_W-1:0]        csr_wdata;

   entry_type                   mirror_slots [MEM_DEPTH];
   int                          mirror_rd [NUM_CLASSES];
   int                          mirror_wr [NUM_CLASSES];
   int                          mirror_fill [NUM_CLASSES];
   logic signed [RUN_W-1:0]     run_setting [3];

   queue_result_type            pending_results [$];
   int                          mismatch_count;
   int                          cycle_count;
   bit                          sender_eager;
   logic [TIME_W-1:0]           clock_ms;

   strict_priority_event_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_priority_req (req_priority_req),
      .req_ttl          (req_ttl),
      .req_payload      (req_payload),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_out_class    (rsp_out_class),
      .rsp_run_priority (rsp_run_priority),
      .rsp_all_empty    (rsp_all_empty),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [RUN_W-1:0] class_run_setting(input int cls);
      if (cls == NUM_CLASSES - 1) return run_setting[CSR_HIGH_RUN];
      if (cls == 0) return run_setting[CSR_LOW_RUN];
      return run_setting[CSR_NORMAL_RUN];
   endfunction

   function automatic queue_result_type predict_queue_step(input logic [CMD_W-1:0] cmd,
                                                           input logic [PRIO_W-1:0] prio,
                                                           input logic [TTL_W-1:0] life,
                                                           input logic [PAYLOAD_W-1:0] word,
                                                           input logic [TIME_W-1:0] now);
      queue_result_type  r;
      int                c;
      entry_type         e;
      logic [TIME_W-1:0] deadline;
      r.status = STAT_DONE;
      r.payload = '0;
      r.cls = '0;
      r.run = '0;
      c = -1;
      if (cmd == CMD_PUSH) begin
         c = (prio >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(prio);
         r.cls = OCLS_W'(c);
         if (mirror_fill[c] >= RING_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            e.payload = word;
            e.ttl = life;
            e.stamp = now;
            mirror_slots[c * RING_DEPTH + mirror_wr[c]] = e;
            mirror_wr[c] = (mirror_wr[c] + 1) % RING_DEPTH;
            mirror_fill[c]++;
         end
      end else if (cmd == CMD_POP) begin
         for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (c < 0 && mirror_fill[k] != 0) c = k;
         end
         if (c < 0) begin
            r.status = STAT_EMPTY;
         end else begin
            e = mirror_slots[c * RING_DEPTH + mirror_rd[c]];
            mirror_rd[c] = (mirror_rd[c] + 1) % RING_DEPTH;
            mirror_fill[c]--;
            r.cls = OCLS_W'(c);
            deadline = e.stamp + TIME_W'(e.ttl);
            if (e.ttl != 0 && now > deadline) begin
               r.status = STAT_EXPIRED;
            end else begin
               r.payload = e.payload;
               r.run = class_run_setting(c);
            end
         end
      end else if (cmd == CMD_CLEAR) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            mirror_rd[k] = 0;
            mirror_wr[k] = 0;
            mirror_fill[k] = 0;
         end
      end
      r.all_empty = 1'b1;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         if (mirror_fill[k] != 0) r.all_empty = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected result: status %0d payload %h class %0d run %0d empty %0b",
                        rsp_status, rsp_out_payload, rsp_out_class, rsp_run_priority,
                        rsp_all_empty);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_out_payload !== want.payload ||
                rsp_out_class !== want.cls || rsp_run_priority !== want.run ||
                rsp_all_empty !== want.all_empty) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"Mismatch: expected status %0d payload %h class %0d run %0d ",
                            "empty %0b, got status %0d payload %h class %0d run %0d empty %0b"},
                           want.status, want.payload, want.cls, want.run, want.all_empty,
                           rsp_status, rsp_out_payload, rsp_out_class, rsp_run_priority,
                           rsp_all_empty);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                            input logic [TTL_W-1:0] life, input logic [PAYLOAD_W-1:0] word,
                            input logic [TIME_W-1:0] now);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_priority_req <= prio;
      req_ttl <= life;
      req_payload <= word;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_queue_step(cmd, prio, life, word, now));
   endtask

   task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio);
      logic [TTL_W-1:0] life;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) life = '0;
      else if (pick < 8) life = TTL_W'($urandom_range(1, 40));
      else life = TTL_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 199) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + TIME_W'($urandom_range(0, 6));
      send_item(cmd, prio, life, $urandom(), clock_ms);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      run_setting[idx] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_run_priorities(input logic [CSR_DAT_W-1:0] low_value,
                                     input logic [CSR_DAT_W-1:0] normal_value,
                                     input logic [CSR_DAT_W-1:0] high_value);
      write_register(CSR_LOW_RUN, low_value);
      write_register(CSR_NORMAL_RUN, normal_value);
      write_register(CSR_HIGH_RUN, high_value);
   endtask

   task automatic test_empty_rings();
      send_item(CMD_POP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_UNUSED, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_CLEAR, 8'h55, 16'hAAAA, 32'h5555_AAAA, 32'hAAAA_5555);
      wait_idle();
   endtask

   task automatic test_class_order();
      send_item(CMD_PUSH, 8'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_PUSH, 8'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 8'd255, 16'h0000, 32'hA5A5_5A5A, 32'h0000_0000);
      send_item(CMD_PUSH, 8'd3, 16'h0000, 32'h5A5A_A5A5, 32'h0000_0000);
      repeat (5) send_item(CMD_POP, 8'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      wait_idle();
   endtask

   task automatic test_expiry();
      send_item(CMD_PUSH, 8'd1, 16'd5, 32'h1111_0001, 32'd100);
      send_item(CMD_POP, 8'd0, 16'd0, 32'h0, 32'd105);
      send_item(CMD_PUSH, 8'd1, 16'd5, 32'h1111_0002, 32'd100);
      send_item(CMD_POP, 8'd0, 16'd0, 32'h0, 32'd106);
      send_item(CMD_PUSH, 8'd2, 16'h0020, 32'h2222_0003, 32'hFFFF_FFF0);
      send_item(CMD_POP, 8'd0, 16'd0, 32'h0, 32'h0000_0010);
      send_item(CMD_PUSH, 8'd0, 16'd0, 32'h3333_0004, 32'd0);
      send_item(CMD_POP, 8'd0, 16'd0, 32'h0, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_clear_with_entries();
      send_item(CMD_PUSH, 8'd0, 16'd9, 32'h4444_0001, 32'd7);
      send_item(CMD_PUSH, 8'd2, 16'd0, 32'h4444_0002, 32'd7);
      send_item(CMD_CLEAR, 8'd0, 16'd0, 32'h0, 32'd7);
      send_item(CMD_POP, 8'd0, 16'd0, 32'h0, 32'd7);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int item_count);
      int sent;
      int kind;
      int burst;
      int target;
      logic [PRIO_W-1:0] prio;
      sent = 0;
      clock_ms = $urandom();
      while (sent < item_count) begin
         kind = $urandom_range(0, 99);
         burst = $urandom_range(1, 20);
         target = $urandom_range(0, NUM_CLASSES - 1);
         sender_eager = ($urandom_range(0, 3) == 0);
         if (kind < 35) begin
            for (int i = 0; i < burst; i++) begin
               prio = PRIO_W'(target);
               if (target == NUM_CLASSES - 1 && $urandom_range(0, 1) == 1)
                  prio = PRIO_W'($urandom_range(NUM_CLASSES - 1, 255));
               send_random(CMD_PUSH, prio);
            end
            sent += burst;
         end else if (kind < 65) begin
            for (int i = 0; i < burst; i++) send_random(CMD_POP, PRIO_W'($urandom()));
            sent += burst;
         end else if (kind < 92) begin
            for (int i = 0; i < burst; i++) begin
               prio = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom())
                                                  : PRIO_W'($urandom_range(0, 2));
               send_random(($urandom_range(0, 1) == 1) ? CMD_PUSH : CMD_POP, prio);
            end
            sent += burst;
         end else if (kind < 95) begin
            send_random(CMD_CLEAR, PRIO_W'($urandom()));
            sent++;
         end else if (kind < 98) begin
            send_random(CMD_UNUSED, PRIO_W'($urandom()));
            sent++;
         end else begin
            wait_idle();
         end
      end
      wait_idle();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_PUSH;
      req_priority_req <= '0;
      req_ttl <= '0;
      req_payload <= '0;
      req_now_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_LOW_RUN;
      csr_wdata <= '0;
      mismatch_count = 0;
      cycle_count = 0;
      sender_eager = 1'b0;
      clock_ms = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         mirror_rd[k] = 0;
         mirror_wr[k] = 0;
         mirror_fill[k] = 0;
      end
      for (int k = 0; k < 3; k++) run_setting[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_rings();
      set_run_priorities(8'hF0, 8'h11, 8'h7F);
      test_class_order();
      test_expiry();
      test_clear_with_entries();

      set_run_priorities(8'h80, 8'h80, 8'h80);
      test_random_traffic(150);
      set_run_priorities(8'h7F, 8'h7F, 8'h7F);
      test_random_traffic(150);
      set_run_priorities(8'h80, 8'h00, 8'h7F);
      test_random_traffic(150);
      set_run_priorities(8'h7F, 8'hFF, 8'h80);
      test_random_traffic(150);
      set_run_priorities(CSR_DAT_W'($urandom()), CSR_DAT_W'($urandom()),
                         CSR_DAT_W'($urandom()));
      test_random_traffic(150);
      set_run_priorities(CSR_DAT_W'($urandom()), CSR_DAT_W'($urandom()),
                         CSR_DAT_W'($urandom()));
      test_random_traffic(150);

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
